[sv/fct_pkg.sv]
// Shared types and constants for the six-plane frustum culling test core.
package fct_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int NUM_PLANES      = 6;
    localparam int IDX_WIDTH       = 3;
    localparam int CMD_WIDTH       = 2;
    localparam int OUT_DATA_WIDTH  = 8;

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_POINT  = 2'd0,
        CMD_SPHERE = 2'd1,
        CMD_CUBE   = 2'd2,
        CMD_LOAD   = 2'd3
    } cmd_t;

endpackage

[sv/fct_cell.sv]
// One plane cell: holds a frustum plane and tests each passing item against it.
module fct_cell #(
    parameter int COORD_WIDTH = fct_pkg::COORD_WIDTH_DEF,
    parameter int CELL_INDEX  = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  fct_pkg::cmd_t                     in_cmd,
    input  logic [fct_pkg::IDX_WIDTH-1:0]     in_idx,
    input  logic signed [COORD_WIDTH-1:0]     in_px,
    input  logic signed [COORD_WIDTH-1:0]     in_py,
    input  logic signed [COORD_WIDTH-1:0]     in_pz,
    input  logic [COORD_WIDTH-2:0]            in_ext,
    input  logic signed [COORD_WIDTH-1:0]     in_off,
    input  logic                              in_inside,
    output logic                              out_valid,
    input  logic                              out_ready,
    output fct_pkg::cmd_t                     out_cmd,
    output logic [fct_pkg::IDX_WIDTH-1:0]     out_idx,
    output logic signed [COORD_WIDTH-1:0]     out_px,
    output logic signed [COORD_WIDTH-1:0]     out_py,
    output logic signed [COORD_WIDTH-1:0]     out_pz,
    output logic [COORD_WIDTH-2:0]            out_ext,
    output logic signed [COORD_WIDTH-1:0]     out_off,
    output logic                              out_inside
);
    import fct_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 8;

    logic signed [W-1:0] nx_reg, ny_reg, nz_reg, d_reg;
    logic [W+1:0]        l1_reg, l1_next;
    logic [W-1:0]        abs_x, abs_y, abs_z;
    logic                plane_we;

    logic                mid_v_reg, mid_v_next, mid_ready;
    logic                out_v_reg, out_v_next, out_stage_ready;

    logic signed [PW-1:0] prod_x_reg, prod_y_reg, prod_z_reg;
    logic signed [PW-1:0] prod_x_next, prod_y_next, prod_z_next;
    logic [PW:0]          ext_prod_reg, ext_prod_next;
    logic signed [W-1:0]  mid_d_reg;

    cmd_t                 mid_cmd_reg;
    logic [IDX_WIDTH-1:0] mid_idx_reg;
    logic signed [W-1:0]  mid_px_reg, mid_py_reg, mid_pz_reg, mid_off_reg;
    logic [W-2:0]         mid_ext_reg;
    logic                 mid_inside_reg;

    cmd_t                 out_cmd_reg;
    logic [IDX_WIDTH-1:0] out_idx_reg;
    logic signed [W-1:0]  out_px_reg, out_py_reg, out_pz_reg, out_off_reg;
    logic [W-2:0]         out_ext_reg;
    logic                 out_inside_reg, out_inside_next;

    logic [SW-1:0]        ext_term;
    logic [SW-1:0]        dist_sum;
    logic                 dist_pos;

    // handshake
    assign out_stage_ready = !out_v_reg || out_ready;
    assign mid_ready       = !mid_v_reg || out_stage_ready;
    assign in_ready        = mid_ready;
    assign mid_v_next      = mid_ready ? in_valid : mid_v_reg;
    assign out_v_next      = out_stage_ready ? mid_v_reg : out_v_reg;

    // plane load
    assign plane_we = in_valid && mid_ready && (in_cmd == CMD_LOAD)
                      && (in_idx == IDX_WIDTH'(CELL_INDEX));
    assign abs_x    = in_px[W-1] ? W'(-in_px) : W'(in_px);
    assign abs_y    = in_py[W-1] ? W'(-in_py) : W'(in_py);
    assign abs_z    = in_pz[W-1] ? W'(-in_pz) : W'(in_pz);
    assign l1_next  = (W+2)'(abs_x) + (W+2)'(abs_y) + (W+2)'(abs_z);

    // multiply stage
    assign prod_x_next   = PW'(nx_reg) * PW'(in_px);
    assign prod_y_next   = PW'(ny_reg) * PW'(in_py);
    assign prod_z_next   = PW'(nz_reg) * PW'(in_pz);
    assign ext_prod_next = (PW+1)'(in_ext) * (PW+1)'(l1_reg);

    // sum and compare stage
    always_comb
    begin
        case (mid_cmd_reg)
            CMD_SPHERE: ext_term = {{(SW-W-15){1'b0}}, mid_ext_reg, 16'h0};
            CMD_CUBE:   ext_term = {{(SW-PW-1){1'b0}}, ext_prod_reg};
            default:    ext_term = '0;
        endcase
    end

    assign dist_sum = {{(SW-PW){prod_x_reg[PW-1]}}, prod_x_reg}
                    + {{(SW-PW){prod_y_reg[PW-1]}}, prod_y_reg}
                    + {{(SW-PW){prod_z_reg[PW-1]}}, prod_z_reg}
                    + {{(SW-W-16){mid_d_reg[W-1]}}, mid_d_reg, 16'h0}
                    + ext_term;
    assign dist_pos        = !dist_sum[SW-1] && (dist_sum != '0);
    assign out_inside_next = mid_inside_reg && dist_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg    <= '0;
            ny_reg    <= '0;
            nz_reg    <= '0;
            d_reg     <= '0;
            l1_reg    <= '0;
            mid_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            mid_v_reg <= mid_v_next;
            out_v_reg <= out_v_next;
            if (plane_we)
            begin
                nx_reg <= in_px;
                ny_reg <= in_py;
                nz_reg <= in_pz;
                d_reg  <= in_off;
                l1_reg <= l1_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && mid_ready)
        begin
            prod_x_reg     <= prod_x_next;
            prod_y_reg     <= prod_y_next;
            prod_z_reg     <= prod_z_next;
            ext_prod_reg   <= ext_prod_next;
            mid_d_reg      <= d_reg;
            mid_cmd_reg    <= in_cmd;
            mid_idx_reg    <= in_idx;
            mid_px_reg     <= in_px;
            mid_py_reg     <= in_py;
            mid_pz_reg     <= in_pz;
            mid_ext_reg    <= in_ext;
            mid_off_reg    <= in_off;
            mid_inside_reg <= in_inside;
        end
        if (mid_v_reg && out_stage_ready)
        begin
            out_cmd_reg    <= mid_cmd_reg;
            out_idx_reg    <= mid_idx_reg;
            out_px_reg     <= mid_px_reg;
            out_py_reg     <= mid_py_reg;
            out_pz_reg     <= mid_pz_reg;
            out_ext_reg    <= mid_ext_reg;
            out_off_reg    <= mid_off_reg;
            out_inside_reg <= out_inside_next;
        end
    end

    assign out_valid  = out_v_reg;
    assign out_cmd    = out_cmd_reg;
    assign out_idx    = out_idx_reg;
    assign out_px     = out_px_reg;
    assign out_py     = out_py_reg;
    assign out_pz     = out_pz_reg;
    assign out_ext    = out_ext_reg;
    assign out_off    = out_off_reg;
    assign out_inside = out_inside_reg;

endmodule

[sv/frustum_culling_test_core.sv]
// Top level of the six-plane frustum culling test core: a chain of plane cells.
// Each plane cell holds two register stages between input accept and result valid.
// Throughput: one item per cycle while not stalled; each cell multiplies in one stage,
// sums and compares next. Ready passes back through the whole chain in the same cycle;
// the input stalls only when all twelve stages hold items and the output is held off.
// Reset: asynchronous, active low; all planes clear to zero and the chain empties.
module frustum_culling_test_core #(
    parameter int COORD_WIDTH = fct_pkg::COORD_WIDTH_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // plane_index, pos_x, pos_y, pos_z, extent, plane_offset
    input  logic [((5*COORD_WIDTH+2+7)/8)*8-1:0]         s_tdata,
    // cmd
    input  logic [fct_pkg::CMD_WIDTH-1:0]                s_tuser,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // inside_res
    output logic [fct_pkg::OUT_DATA_WIDTH-1:0]           m_tdata,
    // load_ack
    output logic                                         m_tuser
);
    import fct_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int NP = NUM_PLANES;
    localparam int FW = $clog2(2 * NP + 1);

    logic [NP:0]          link_valid, link_ready, link_inside;
    cmd_t                 link_cmd [0:NP];
    logic [IDX_WIDTH-1:0] link_idx [0:NP];
    logic signed [W-1:0]  link_px  [0:NP];
    logic signed [W-1:0]  link_py  [0:NP];
    logic signed [W-1:0]  link_pz  [0:NP];
    logic [W-2:0]         link_ext [0:NP];
    logic signed [W-1:0]  link_off [0:NP];

    logic [FW-1:0]        flight_reg, flight_next;
    logic                 in_acc, out_acc;

    assign link_valid[0]  = s_tvalid;
    assign s_tready       = link_ready[0];
    assign link_cmd[0]    = cmd_t'(s_tuser);
    assign link_idx[0]    = s_tdata[IDX_WIDTH-1:0];
    assign link_px[0]     = s_tdata[IDX_WIDTH +: W];
    assign link_py[0]     = s_tdata[IDX_WIDTH+W +: W];
    assign link_pz[0]     = s_tdata[IDX_WIDTH+2*W +: W];
    assign link_ext[0]    = s_tdata[IDX_WIDTH+3*W +: W-1];
    assign link_off[0]    = s_tdata[IDX_WIDTH+4*W-1 +: W];
    assign link_inside[0] = 1'b1;

    for (genvar i = 0; i < NP; i++)
    begin : g_cell
        fct_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .CELL_INDEX  (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_valid   (link_valid[i]),
            .in_ready   (link_ready[i]),
            .in_cmd     (link_cmd[i]),
            .in_idx     (link_idx[i]),
            .in_px      (link_px[i]),
            .in_py      (link_py[i]),
            .in_pz      (link_pz[i]),
            .in_ext     (link_ext[i]),
            .in_off     (link_off[i]),
            .in_inside  (link_inside[i]),
            .out_valid  (link_valid[i+1]),
            .out_ready  (link_ready[i+1]),
            .out_cmd    (link_cmd[i+1]),
            .out_idx    (link_idx[i+1]),
            .out_px     (link_px[i+1]),
            .out_py     (link_py[i+1]),
            .out_pz     (link_pz[i+1]),
            .out_ext    (link_ext[i+1]),
            .out_off    (link_off[i+1]),
            .out_inside (link_inside[i+1])
        );
    end

    assign link_ready[NP] = m_tready;
    assign m_tvalid       = link_valid[NP];
    assign m_tuser        = (link_cmd[NP] == CMD_LOAD);
    assign m_tdata        = {{(OUT_DATA_WIDTH-1){1'b0}},
                             link_inside[NP] && (link_cmd[NP] != CMD_LOAD)};

    // items in flight
    assign in_acc      = s_tvalid && s_tready;
    assign out_acc     = m_tvalid && m_tready;
    assign flight_next = flight_reg + FW'(in_acc) - FW'(out_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flight_reg <= '0;
        end
        else
        begin
            flight_reg <= flight_next;
        end
    end

    a_stall_only_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while output side is free");

    a_flight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        flight_reg <= FW'(2 * NP))
        else $error("more items in flight than pipeline stages");

    a_valid_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (flight_reg != '0))
        else $error("result presented with no item in flight");

endmodule

[dv/testbench.sv]
// Self-checking testbench for the six-plane frustum culling core: directed table, random scenes.
`timescale 1ns / 1ps

module testbench;
    import fct_pkg::*;

    localparam int CW          = 32;
    localparam int TDATA_W     = ((5*CW+2+7)/8)*8;
    localparam int ITEM_TARGET = 1050;
    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_WAIT    = 13;

    localparam logic [31:0] Q_ONE    = 32'h0001_0000;
    localparam logic [31:0] Q_NEG1   = 32'hFFFF_0000;
    localparam logic [31:0] Q_TEN    = 32'h000A_0000;
    localparam logic [31:0] Q_ELEVEN = 32'h000B_0000;
    localparam logic [31:0] Q_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN    = 32'h8000_0000;
    localparam logic [30:0] EXT_ONE  = 31'h0001_0000;
    localparam logic [30:0] EXT_ONEP = 31'h0001_0001;
    localparam logic [30:0] EXT_TWO  = 31'h0002_0000;
    localparam logic [30:0] EXT_MAX  = 31'h7FFF_FFFF;

    localparam int STYLE_BOX  = 0;
    localparam int STYLE_TILT = 2;
    localparam int STYLE_WILD = 3;

    typedef struct packed {
        cmd_t        cmd;
        logic [2:0]  plane_index;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [30:0] extent;
        logic [31:0] plane_offset;
    } cull_item_t;

    typedef struct packed {
        logic visible;
        logic ack;
    } cull_verdict_t;

    typedef struct packed {
        cull_item_t item;
        logic       typed;
        logic       visible;
        logic       ack;
    } cull_row_t;

    localparam int NUM_ROWS = 26;
    localparam cull_row_t DIRECTED [NUM_ROWS] = '{
        '{'{CMD_POINT,  3'd0, 32'h0, 32'h0, 32'h0, 31'h0, 32'h0}, 1'b1, 1'b0, 1'b0},
        '{'{CMD_POINT,  3'd7, Q_MAX, Q_MIN, Q_MAX, EXT_MAX, Q_MIN}, 1'b1, 1'b0, 1'b0},
        '{'{CMD_SPHERE, 3'd0, 32'h0, 32'h0, 32'h0, 31'h0, 32'h0}, 1'b1, 1'b0, 1'b0},
        '{'{CMD_SPHERE, 3'd0, 32'h0, 32'h0, 32'h0, 31'h1, 32'h0}, 1'b1, 1'b1, 1'b0},
        '{'{CMD_SPHERE, 3'd5, Q_MIN, Q_MAX, Q_MIN, EXT_MAX, 32'h0}, 1'b1, 1'b1, 1'b0},
        '{'{CMD_CUBE,   3'd0, 32'h0, 32'h0, 32'h0, 31'h0, 32'h0}, 1'b1, 1'b0, 1'b0},
        '{'{CMD_CUBE,   3'd2, Q_MAX, Q_MAX, Q_MIN, EXT_MAX, 32'h0}, 1'b1, 1'b0, 1'b0},
        '{'{CMD_LOAD,   3'd7, Q_ONE, Q_ONE, Q_ONE, 31'h0, Q_TEN}, 1'b1, 1'b0, 1'b1},
        '{'{CMD_LOAD,   3'd6, Q_NEG1, Q_ONE, Q_ONE, EXT_MAX, Q_MIN}, 1'b1, 1'b0, 1'b1},
        '{'{CMD_SPHERE, 3'd0, 32'h0, 32'h0, 32'h0, 31'h1, 32'h0}, 1'b1, 1'b1, 1'b0},
        '{'{CMD_LOAD,   3'd0, Q_ONE, 32'h0, 32'h0, 31'h0, Q_TEN}, 1'b1, 1'b0, 1'b1},
        '{'{CMD_LOAD,   3'd1, Q_NEG1, 32'h0, 32'h0, 31'h0, Q_TEN}, 1'b1, 1'b0, 1'b1},
        '{'{CMD_LOAD,   3'd2, 32'h0, Q_ONE, 32'h0, 31'h0, Q_TEN}, 1'b1, 1'b0, 1'b1},
        '{'{CMD_LOAD,   3'd3, 32'h0, Q_NEG1, 32'h0, 31'h0, Q_TEN}, 1'b1, 1'b0, 1'b1},
        '{'{CMD_LOAD,   3'd4, 32'h0, 32'h0, Q_ONE, 31'h0, Q_TEN}, 1'b1, 1'b0, 1'b1},
        '{'{CMD_LOAD,   3'd5, 32'h0, 32'h0, Q_NEG1, 31'h0, Q_TEN}, 1'b1, 1'b0, 1'b1},
        '{'{CMD_POINT,  3'd0, 32'h0, 32'h0, 32'h0, EXT_MAX, 32'h0}, 1'b1, 1'b1, 1'b0},
        '{'{CMD_POINT,  3'd0, Q_TEN, 32'h0, 32'h0, 31'h0, 32'h0}, 1'b1, 1'b0, 1'b0},
        '{'{CMD_SPHERE, 3'd0, Q_ELEVEN, 32'h0, 32'h0, EXT_ONE, 32'h0}, 1'b1, 1'b0, 1'b0},
        '{'{CMD_SPHERE, 3'd0, Q_ELEVEN, 32'h0, 32'h0, EXT_ONEP, 32'h0}, 1'b0, 1'b0, 1'b0},
        '{'{CMD_CUBE,   3'd0, Q_ELEVEN, 32'h0, 32'h0, EXT_ONE, 32'h0}, 1'b1, 1'b0, 1'b0},
        '{'{CMD_CUBE,   3'd0, Q_ELEVEN, 32'h0, 32'h0, EXT_TWO, 32'h0}, 1'b0, 1'b0, 1'b0},
        '{'{CMD_LOAD,   3'd0, Q_MIN, Q_MIN, Q_MIN, 31'h0, Q_MIN}, 1'b1, 1'b0, 1'b1},
        '{'{CMD_POINT,  3'd0, Q_MIN, Q_MIN, Q_MIN, 31'h0, 32'h0}, 1'b0, 1'b0, 1'b0},
        '{'{CMD_CUBE,   3'd0, Q_MAX, Q_MAX, Q_MAX, EXT_MAX, 32'h0}, 1'b0, 1'b0, 1'b0},
        '{'{CMD_SPHERE, 3'd0, Q_MAX, Q_MIN, Q_MAX, EXT_MAX, 32'h0}, 1'b0, 1'b0, 1'b0}
    };

    logic                      clk      = 1'b0;
    logic                      rst_n    = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [TDATA_W-1:0]        s_tdata  = '0;
    logic [CMD_WIDTH-1:0]      s_tuser  = CMD_POINT;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_DATA_WIDTH-1:0] m_tdata;
    logic                      m_tuser;

    logic signed [31:0] plane_nx [NUM_PLANES];
    logic signed [31:0] plane_ny [NUM_PLANES];
    logic signed [31:0] plane_nz [NUM_PLANES];
    logic signed [31:0] plane_d  [NUM_PLANES];

    cull_verdict_t pending_verdicts [$];
    int  items_sent    = 0;
    int  verdicts_seen = 0;
    int  error_count   = 0;
    int  idle_cycles   = 0;
    bit  tx_burst      = 1'b0;
    bit  rx_burst      = 1'b0;
    bit  tx_draining   = 1'b0;
    bit  rx_hold       = 1'b0;
    bit  hold_done     = 1'b0;

    frustum_culling_test_core #(.COORD_WIDTH(CW)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    function automatic logic signed [127:0] plane_distance(int p, logic signed [127:0] x,
                                                           logic signed [127:0] y,
                                                           logic signed [127:0] z);
        logic signed [127:0] nx, ny, nz, d;
        nx = plane_nx[p];
        ny = plane_ny[p];
        nz = plane_nz[p];
        d  = plane_d[p];
        return nx * x + ny * y + nz * z + (d <<< 16);
    endfunction

    function automatic cull_verdict_t judge_item(cull_item_t it);
        cull_verdict_t       v;
        logic signed [127:0] x, y, z, e;
        logic                hit;
        v.visible = 1'b1;
        v.ack     = 1'b0;
        if (it.cmd == CMD_LOAD)
        begin
            if (it.plane_index < NUM_PLANES)
            begin
                plane_nx[it.plane_index] = it.pos_x;
                plane_ny[it.plane_index] = it.pos_y;
                plane_nz[it.plane_index] = it.pos_z;
                plane_d[it.plane_index]  = it.plane_offset;
            end
            v.visible = 1'b0;
            v.ack     = 1'b1;
            return v;
        end
        x = $signed(it.pos_x);
        y = $signed(it.pos_y);
        z = $signed(it.pos_z);
        e = {97'd0, it.extent};
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            case (it.cmd)
                CMD_POINT:
                    if (plane_distance(p, x, y, z) <= 0)
                        v.visible = 1'b0;
                CMD_SPHERE:
                    if (plane_distance(p, x, y, z) + (e <<< 16) <= 0)
                        v.visible = 1'b0;
                default:
                begin
                    hit = 1'b0;
                    for (int c = 0; c < 8; c++)
                        if (plane_distance(p, (c & 1) ? x + e : x - e,
                                              (c & 2) ? y + e : y - e,
                                              (c & 4) ? z + e : z - e) > 0)
                            hit = 1'b1;
                    if (!hit)
                        v.visible = 1'b0;
                end
            endcase
        end
        return v;
    endfunction

    function automatic logic [31:0] rand_span(int unsigned span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic int draw_wait(bit burst);
        return burst ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic cull_item_t make_plane(int style, int slot);
        cull_item_t it;
        logic [31:0] mag;
        it.cmd          = CMD_LOAD;
        it.plane_index  = slot[2:0];
        it.extent       = 31'($urandom);
        it.pos_x        = '0;
        it.pos_y        = '0;
        it.pos_z        = '0;
        it.plane_offset = $urandom_range(0, 40 << 16) - (5 << 16);
        if (style == STYLE_WILD)
        begin
            it.pos_x        = $urandom;
            it.pos_y        = $urandom;
            it.pos_z        = $urandom;
            it.plane_offset = $urandom;
        end
        else if (style == STYLE_TILT)
        begin
            it.pos_x        = rand_span(1 << 16);
            it.pos_y        = rand_span(1 << 16);
            it.pos_z        = rand_span(1 << 16);
            it.plane_offset = $urandom_range(0, 60 << 16) - (10 << 16);
        end
        else
        begin
            mag = Q_ONE * $urandom_range(1, 4);
            if (slot % 2)
                mag = -mag;
            case (slot / 2)
                0:       it.pos_x = mag;
                1:       it.pos_y = mag;
                default: it.pos_z = mag;
            endcase
        end
        return it;
    endfunction

    function automatic cull_item_t make_probe(int style);
        cull_item_t it;
        it.cmd          = cmd_t'(2'($urandom_range(0, 2)));
        it.plane_index  = 3'($urandom_range(0, 7));
        it.plane_offset = $urandom;
        if (style == STYLE_WILD)
        begin
            it.pos_x = $urandom;
            it.pos_y = $urandom;
            it.pos_z = $urandom;
        end
        else
        begin
            it.pos_x = rand_span(40 << 16);
            it.pos_y = rand_span(40 << 16);
            it.pos_z = rand_span(40 << 16);
        end
        case ($urandom_range(0, 7))
            0:       it.extent = '0;
            1:       it.extent = 31'($urandom);
            default: it.extent = 31'($urandom_range(0, 16 << 16));
        endcase
        return it;
    endfunction

    function automatic cull_item_t make_noise();
        cull_item_t it;
        it.cmd          = cmd_t'(2'($urandom_range(0, 3)));
        it.plane_index  = 3'($urandom_range(0, 7));
        it.pos_x        = $urandom;
        it.pos_y        = $urandom;
        it.pos_z        = $urandom;
        it.extent       = 31'($urandom);
        it.plane_offset = $urandom;
        return it;
    endfunction

    task automatic drive_item(cull_item_t it, bit typed, logic visible, logic ack);
        cull_verdict_t v;
        int            gap;
        gap = draw_wait(tx_burst);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {6'd0, it.plane_offset, it.extent, it.pos_z, it.pos_y, it.pos_x,
                     it.plane_index};
        do @(posedge clk); while (!s_tready);
        v = judge_item(it);
        if (typed)
        begin
            v.visible = visible;
            v.ack     = ack;
        end
        pending_verdicts.push_back(v);
        items_sent++;
    endtask

    task automatic wait_drained();
        tx_draining = 1'b1;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        tx_draining = 1'b0;
    endtask

    task automatic flag_error(string what, int expv, int gotv);
        error_count++;
        if (error_count <= 10)
            $display("mismatch at %0t: %s expected %0d got %0d", $time, what, expv, gotv);
    endtask

    initial
    begin
        int style;
        int count;
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            plane_nx[p] = '0;
            plane_ny[p] = '0;
            plane_nz[p] = '0;
            plane_d[p]  = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NUM_ROWS; r++)
            drive_item(DIRECTED[r].item, DIRECTED[r].typed, DIRECTED[r].visible,
                       DIRECTED[r].ack);
        wait_drained();

        while (items_sent < ITEM_TARGET)
        begin
            style    = $urandom_range(STYLE_BOX, STYLE_WILD);
            tx_burst = ($urandom_range(0, 3) == 0);
            for (int p = 0; p < NUM_PLANES; p++)
                drive_item(make_plane(style, p), 1'b0, 1'b0, 1'b0);
            if ($urandom_range(0, 3) == 0)
                drive_item(make_plane(STYLE_WILD, $urandom_range(6, 7)), 1'b0, 1'b0, 1'b0);
            count = $urandom_range(20, 50);
            for (int k = 0; k < count; k++)
            begin
                if ($urandom_range(0, 15) == 0)
                    drive_item(make_noise(), 1'b0, 1'b0, 1'b0);
                else
                    drive_item(make_probe(style), 1'b0, 1'b0, 1'b0);
            end
            if (!rx_hold && $urandom_range(0, 4) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        cull_verdict_t want;
        int            stall;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = draw_wait(rx_burst);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            if (pending_verdicts.size() == 0)
                flag_error("unexpected result, inside_res", -1, m_tdata[0]);
            else
            begin
                want = pending_verdicts.pop_front();
                if (m_tdata[0] !== want.visible)
                    flag_error("inside_res", want.visible, m_tdata[0]);
                if (m_tuser !== want.ack)
                    flag_error("load_ack", want.ack, m_tuser);
            end
            verdicts_seen++;
            if (verdicts_seen % 50 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            if (!hold_done && verdicts_seen >= HOLD_AT && !tx_draining)
            begin
                hold_done = 1'b1;
                rx_hold   = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold   = 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
